@@ hdl/elg_pkg.sv @@
// shared types, constants and microprogram for the elgamal encryption block
`default_nettype none

package elg_pkg;

    localparam int MOD_WIDTH_DEF = 31;
    localparam int PC_W          = 4;

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_MODULUS    = 2'd0,
        REG_GENERATOR  = 2'd1,
        REG_PUBLIC_KEY = 2'd2,
        REG_NONE       = 2'd3
    } t_reg_idx;

    // microinstruction kinds
    typedef enum logic [2:0] {
        OP_WAIT_IN,     // wait for an input word
        OP_MUL,         // dst = a * b mod p on the shared multiplier
        OP_TEST,        // jump to target when the current exponent bit is zero
        OP_NEXT,        // shift exponent, loop to target until all bits are done
        OP_EMIT         // load the result word, then jump to target
    } t_op;

    // operand sources
    typedef enum logic [2:0] {
        SRC_ONE,
        SRC_GEN,
        SRC_PUB,
        SRC_MSG,
        SRC_BG,
        SRC_BY,
        SRC_RG,
        SRC_RY
    } t_src;

    // multiplier destinations
    typedef enum logic [2:0] {
        DST_NONE,
        DST_MSG,
        DST_BG,
        DST_BY,
        DST_RG,
        DST_RY
    } t_dst;

    typedef struct packed {
        t_op             op;
        t_src            src_a;
        t_src            src_b;
        t_dst            dst;
        logic [PC_W-1:0] target;
    } t_ctrl;

    function automatic t_ctrl mk(t_op op, t_src a, t_src b, t_dst d, logic [PC_W-1:0] tgt);
        t_ctrl c;
        c.op     = op;
        c.src_a  = a;
        c.src_b  = b;
        c.dst    = d;
        c.target = tgt;
        return c;
    endfunction

    // the program: reduce operands, ladder over exponent bits lsb first, final product
    function automatic t_ctrl micro_rom(logic [PC_W-1:0] pc);
        t_ctrl c;
        case (pc)
            4'd0:    c = mk(OP_WAIT_IN, SRC_ONE, SRC_ONE, DST_NONE, 4'd0);
            4'd1:    c = mk(OP_MUL,     SRC_ONE, SRC_GEN, DST_BG,   4'd0);
            4'd2:    c = mk(OP_MUL,     SRC_ONE, SRC_PUB, DST_BY,   4'd0);
            4'd3:    c = mk(OP_MUL,     SRC_ONE, SRC_MSG, DST_MSG,  4'd0);
            4'd4:    c = mk(OP_MUL,     SRC_ONE, SRC_ONE, DST_RG,   4'd0);
            4'd5:    c = mk(OP_MUL,     SRC_ONE, SRC_ONE, DST_RY,   4'd0);
            4'd6:    c = mk(OP_TEST,    SRC_ONE, SRC_ONE, DST_NONE, 4'd9);
            4'd7:    c = mk(OP_MUL,     SRC_BG,  SRC_RG,  DST_RG,   4'd0);
            4'd8:    c = mk(OP_MUL,     SRC_BY,  SRC_RY,  DST_RY,   4'd0);
            4'd9:    c = mk(OP_MUL,     SRC_BG,  SRC_BG,  DST_BG,   4'd0);
            4'd10:   c = mk(OP_MUL,     SRC_BY,  SRC_BY,  DST_BY,   4'd0);
            4'd11:   c = mk(OP_NEXT,    SRC_ONE, SRC_ONE, DST_NONE, 4'd6);
            4'd12:   c = mk(OP_MUL,     SRC_MSG, SRC_RY,  DST_RY,   4'd0);
            4'd13:   c = mk(OP_EMIT,    SRC_ONE, SRC_ONE, DST_NONE, 4'd0);
            default: c = mk(OP_WAIT_IN, SRC_ONE, SRC_ONE, DST_NONE, 4'd0);
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/elgamal_encrypt.sv @@
// elgamal encryption top level: config registers, microcoded sequencer, result register
//
// channel  | dir | handshake                  | contents
// ---------+-----+----------------------------+------------------------------------
// s_axis   | in  | s_axis_tvalid/tready       | message, ephemeral exponent k
// m_axis   | out | m_axis_tvalid/tready       | c1 = g^k mod p, c2 = m*y^k mod p
// apb      | in  | psel/penable/pwrite/pready | modulus, generator, public key
//
// one word at a time; each multiply step starts the shared bit-serial multiplier and
// holds until the multiplier reports done
// reset is synchronous and active low; it clears the sequencer and output valid
// a finished result waits in the output register while the next word is taken;
// only the emit step holds while that register is still full
`default_nettype none

module elgamal_encrypt #(
    parameter int MOD_WIDTH = elg_pkg::MOD_WIDTH_DEF,
    localparam int TD_W     = ((2 * MOD_WIDTH + 7) / 8) * 8,
    localparam int APB_DW   = (MOD_WIDTH > 32) ? 64 : 32,
    localparam int APB_AW   = (MOD_WIDTH > 32) ? 5 : 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input stream
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [TD_W-1:0]   s_axis_tdata,   // message, ephemeral_exp, zero pad
    // output stream
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [TD_W-1:0]        m_axis_tdata,   // cipher_first, cipher_second, zero pad
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    import elg_pkg::*;

    localparam int STRIDE = (MOD_WIDTH > 32) ? 3 : 2;
    localparam int BIT_W  = $clog2(MOD_WIDTH);
    localparam int PAD_W  = TD_W - 2 * MOD_WIDTH;

    // configuration registers
    logic [MOD_WIDTH-1:0] r_mod, r_gen, r_pub;
    t_reg_idx             cfg_idx;
    logic                 cfg_wr;

    // sequencer state
    logic [PC_W-1:0]      r_pc,     n_pc;
    logic                 r_issued, n_issued;
    logic [BIT_W-1:0]     r_bit,    n_bit;
    logic [MOD_WIDTH-1:0] r_k,      n_k;

    // datapath registers
    logic [MOD_WIDTH-1:0] r_msg, n_msg;
    logic [MOD_WIDTH-1:0] r_bg,  n_bg;
    logic [MOD_WIDTH-1:0] r_by,  n_by;
    logic [MOD_WIDTH-1:0] r_rg,  n_rg;
    logic [MOD_WIDTH-1:0] r_ry,  n_ry;

    // result register
    logic                 r_out_valid, n_out_valid;
    logic [MOD_WIDTH-1:0] r_c1, n_c1;
    logic [MOD_WIDTH-1:0] r_c2, n_c2;

    t_ctrl                ctrl;
    logic                 mul_start;
    logic                 mul_done;
    logic [MOD_WIDTH-1:0] mul_res;
    logic [MOD_WIDTH-1:0] opa, opb;
    logic                 in_acc;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[STRIDE+1:STRIDE]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_WIDTH'(3);
            r_gen <= MOD_WIDTH'(2);
            r_pub <= MOD_WIDTH'(1);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_MODULUS:    r_mod <= pwdata[MOD_WIDTH-1:0];
                REG_GENERATOR:  r_gen <= pwdata[MOD_WIDTH-1:0];
                REG_PUBLIC_KEY: r_pub <= pwdata[MOD_WIDTH-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_MODULUS:    prdata = APB_DW'(r_mod);
            REG_GENERATOR:  prdata = APB_DW'(r_gen);
            REG_PUBLIC_KEY: prdata = APB_DW'(r_pub);
            default:        prdata = '0;
        endcase
    end

    // ---------------- shared modular multiplier ----------------
    elg_mulmod #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_a      (opa),
        .i_b      (opb),
        .i_p      (r_mod),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    // operand select from the control word
    function automatic logic [MOD_WIDTH-1:0] pick(
        t_src s, logic [MOD_WIDTH-1:0] gen, logic [MOD_WIDTH-1:0] pub,
        logic [MOD_WIDTH-1:0] msg, logic [MOD_WIDTH-1:0] bg, logic [MOD_WIDTH-1:0] by,
        logic [MOD_WIDTH-1:0] rg, logic [MOD_WIDTH-1:0] ry);
        logic [MOD_WIDTH-1:0] v;
        case (s)
            SRC_ONE: v = MOD_WIDTH'(1);
            SRC_GEN: v = gen;
            SRC_PUB: v = pub;
            SRC_MSG: v = msg;
            SRC_BG:  v = bg;
            SRC_BY:  v = by;
            SRC_RG:  v = rg;
            SRC_RY:  v = ry;
            default: v = MOD_WIDTH'(1);
        endcase
        return v;
    endfunction

    assign ctrl = micro_rom(r_pc);
    assign opa  = pick(ctrl.src_a, r_gen, r_pub, r_msg, r_bg, r_by, r_rg, r_ry);
    assign opb  = pick(ctrl.src_b, r_gen, r_pub, r_msg, r_bg, r_by, r_rg, r_ry);

    assign s_axis_tready = (ctrl.op == OP_WAIT_IN);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // ---------------- sequencer registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_issued    <= 1'b0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_issued    <= n_issued;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
        r_k   <= n_k;
        r_msg <= n_msg;
        r_bg  <= n_bg;
        r_by  <= n_by;
        r_rg  <= n_rg;
        r_ry  <= n_ry;
        r_c1  <= n_c1;
        r_c2  <= n_c2;
    end

    // ---------------- step decode and next state ----------------
    always_comb begin
        n_pc        = r_pc;
        n_issued    = r_issued;
        n_bit       = r_bit;
        n_k         = r_k;
        n_msg       = r_msg;
        n_bg        = r_bg;
        n_by        = r_by;
        n_rg        = r_rg;
        n_ry        = r_ry;
        n_c1        = r_c1;
        n_c2        = r_c2;
        mul_start   = 1'b0;
        // output register drains independently of the program
        n_out_valid = r_out_valid && !m_axis_tready;

        case (ctrl.op)
            OP_WAIT_IN: begin
                if (in_acc) begin
                    n_msg = s_axis_tdata[MOD_WIDTH-1:0];
                    n_k   = s_axis_tdata[2*MOD_WIDTH-1:MOD_WIDTH];
                    n_bit = '0;
                    n_pc  = r_pc + 1'b1;
                end
            end
            OP_MUL: begin
                if (!r_issued) begin
                    mul_start = 1'b1;
                    n_issued  = 1'b1;
                end else if (mul_done) begin
                    n_issued = 1'b0;
                    n_pc     = r_pc + 1'b1;
                    case (ctrl.dst)
                        DST_MSG: n_msg = mul_res;
                        DST_BG:  n_bg  = mul_res;
                        DST_BY:  n_by  = mul_res;
                        DST_RG:  n_rg  = mul_res;
                        DST_RY:  n_ry  = mul_res;
                        default: ;
                    endcase
                end
            end
            OP_TEST: begin
                // skip both accumulations when this exponent bit is clear
                n_pc = r_k[0] ? r_pc + 1'b1 : ctrl.target;
            end
            OP_NEXT: begin
                n_k = r_k >> 1;
                if (r_bit == BIT_W'(MOD_WIDTH - 1)) begin
                    n_pc = r_pc + 1'b1;
                end else begin
                    n_bit = r_bit + 1'b1;
                    n_pc  = ctrl.target;
                end
            end
            OP_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    // zero modulus gives zero results
                    n_c1 = (r_mod == '0) ? '0 : r_rg;
                    n_c2 = (r_mod == '0) ? '0 : r_ry;
                    n_pc = ctrl.target;
                end
            end
            default: n_pc = '0;
        endcase
    end

    // ---------------- output word ----------------
    assign m_axis_tvalid = r_out_valid;
    generate
        if (PAD_W > 0) begin : g_pad
            assign m_axis_tdata = {PAD_W'(0), r_c2, r_c1};
        end else begin : g_nopad
            assign m_axis_tdata = {r_c2, r_c1};
        end
    endgenerate

endmodule

`default_nettype wire

@@ hdl/elg_mulmod.sv @@
// bit-serial interleaved modular multiplier, msb of b first
`default_nettype none

module elg_mulmod #(
    parameter int MOD_WIDTH = elg_pkg::MOD_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [MOD_WIDTH-1:0] i_a,      // below p, or one
    input  wire logic [MOD_WIDTH-1:0] i_b,      // any value
    input  wire logic [MOD_WIDTH-1:0] i_p,
    output logic                      o_done,
    output logic [MOD_WIDTH-1:0]      o_result
);

    localparam int CNT_W = $clog2(MOD_WIDTH);

    logic                 r_busy,  n_busy;
    logic                 r_phase, n_phase;
    logic                 r_done,  n_done;
    logic [CNT_W-1:0]     r_cnt,   n_cnt;
    logic [MOD_WIDTH-1:0] r_acc,   n_acc;
    logic [MOD_WIDTH-1:0] r_a,     n_a;
    logic [MOD_WIDTH-1:0] r_b,     n_b;
    logic [MOD_WIDTH-1:0] r_p,     n_p;
    logic [MOD_WIDTH:0]   wide;
    logic [MOD_WIDTH:0]   diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_busy  <= n_busy;
            r_phase <= n_phase;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_p   <= n_p;
    end

    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_a     = r_a;
        n_b     = r_b;
        n_p     = r_p;
        // phase 0 doubles, phase 1 adds a when the current bit of b is set
        if (!r_phase) begin
            wide = {r_acc, 1'b0};
        end else begin
            wide = {1'b0, r_acc} + (r_b[MOD_WIDTH-1] ? {1'b0, r_a} : '0);
        end
        diff = wide - {1'b0, r_p};
        if (i_start) begin
            n_busy  = 1'b1;
            n_phase = 1'b0;
            n_cnt   = '0;
            n_acc   = '0;
            n_a     = i_a;
            n_b     = i_b;
            n_p     = i_p;
        end else if (r_busy) begin
            n_acc   = (wide >= {1'b0, r_p}) ? diff[MOD_WIDTH-1:0] : wide[MOD_WIDTH-1:0];
            n_phase = ~r_phase;
            if (r_phase) begin
                n_b = {r_b[MOD_WIDTH-2:0], 1'b0};
                if (r_cnt == CNT_W'(MOD_WIDTH - 1)) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

`default_nettype wire

@@ verif/elgamal_encrypt_tb.sv @@
// self-checking testbench for the elgamal encryption block: stream stimulus, apb setup, scoreboard
`timescale 1ns / 100ps

module elgamal_encrypt_tb;

    import elg_pkg::*;

    localparam int W      = MOD_WIDTH_DEF;
    localparam int TD_W   = ((2 * W + 7) / 8) * 8;
    localparam int APB_DW = (W > 32) ? 64 : 32;
    localparam int APB_AW = (W > 32) ? 5 : 4;
    localparam logic [W-1:0] ALL_ONES = '1;

    // one plaintext word and one ciphertext word
    typedef struct {
        logic [W-1:0] msg;
        logic [W-1:0] k;
    } t_plain;

    typedef struct {
        logic [W-1:0] c1;
        logic [W-1:0] c2;
    } t_cipher;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [TD_W-1:0]   s_axis_tdata = '0;   // message, ephemeral_exp, zero pad
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [TD_W-1:0]   m_axis_tdata;        // cipher_first, cipher_second, zero pad
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    elgamal_encrypt dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // our copy of the key registers, reset values of the block
    logic [W-1:0] cfg_p = W'(3);
    logic [W-1:0] cfg_g = W'(2);
    logic [W-1:0] cfg_y = W'(1);

    t_plain  msg_q[$];      // plaintext words waiting to be offered
    t_cipher cipher_q[$];   // ciphertexts owed by the block, oldest first
    t_plain  tx_word;       // word currently offered on the input
    int      tx_idle = 0;
    int      rx_idle = 0;
    bit      tx_quiet = 1'b0;
    bit      rx_quiet = 1'b0;
    logic    rx_hold = 1'b0;
    int      words_out = 0;
    int      err_count = 0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // product mod p; operands stay below 2^31 so 64 bits never overflow
    function automatic logic [W-1:0] mod_mul(logic [W-1:0] a, logic [W-1:0] b,
                                             logic [W-1:0] p);
        logic [63:0] prod;
        prod = 64'(a) * 64'(b);
        return W'(prod % 64'(p));
    endfunction

    // square and multiply over every bit of the exponent, lsb first
    function automatic logic [W-1:0] mod_pow(logic [W-1:0] base, logic [W-1:0] e,
                                             logic [W-1:0] p);
        logic [W-1:0] acc;
        acc = W'(64'd1 % 64'(p));
        for (int i = 0; i < W; i++) begin
            if (e[i])
                acc = mod_mul(acc, base, p);
            base = mod_mul(base, base, p);
        end
        return acc;
    endfunction

    // c1 = g^k, c2 = m * y^k, everything mod p; a zero modulus gives zeros
    function automatic t_cipher elgamal_cipher(t_plain w);
        t_cipher c;
        logic [W-1:0] yk;
        c.c1 = '0;
        c.c2 = '0;
        if (cfg_p != 0) begin
            c.c1 = mod_pow(W'(64'(cfg_g) % 64'(cfg_p)), w.k, cfg_p);
            yk   = mod_pow(W'(64'(cfg_y) % 64'(cfg_p)), w.k, cfg_p);
            c.c2 = mod_mul(W'(64'(w.msg) % 64'(cfg_p)), yk, cfg_p);
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
        err_count++;
        $display("%0t mismatch on %s: got %h want %h (word %0d)",
                 $realtime, what, got, want, words_out);
    endtask

    // queue a plaintext word; called away from the rising edge
    task automatic push_plain(logic [W-1:0] m, logic [W-1:0] k);
        t_plain w;
        w.msg = m;
        w.k   = k;
        msg_q.push_back(w);
    endtask

    // wait until nothing is pending or owed, then a short settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (msg_q.size() != 0 || s_axis_tvalid || cipher_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // apb write: setup cycle, access cycle, register taken at the access edge
    task automatic write_reg(t_reg_idx idx, logic [APB_DW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        // only the low MOD_WIDTH bits are kept; unknown indexes are dropped
        case (idx)
            REG_MODULUS:    cfg_p = value[W-1:0];
            REG_GENERATOR:  cfg_g = value[W-1:0];
            REG_PUBLIC_KEY: cfg_y = value[W-1:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // full key setup for one random phase
    task automatic random_setting(int ph);
        logic [W-1:0] p;
        case (ph)
            0:       p = ALL_ONES;                          // largest prime that fits
            1:       p = W'(3);                             // smallest legal modulus
            default: begin
                case ($urandom_range(0, 3))
                    0:       p = W'($urandom_range(3, 255));
                    1:       p = W'($urandom_range(3, 65535));
                    default: p = W'($urandom_range(3, 32'h7fff_ffff));
                endcase
            end
        endcase
        write_reg(REG_MODULUS, APB_DW'(p));
        // generator and key may be at or above p, bit 31 of the bus toggles too
        write_reg(REG_GENERATOR, ($urandom_range(0, 2) == 0) ? APB_DW'($urandom)
                                 : APB_DW'($urandom_range(0, 32'(p) - 1)));
        write_reg(REG_PUBLIC_KEY, ($urandom_range(0, 2) == 0) ? APB_DW'($urandom)
                                  : APB_DW'($urandom_range(0, 32'(p) - 1)));
        if (ph == 4)
            write_reg(REG_NONE, APB_DW'($urandom));
    endtask

    // random words: messages mostly reduced, exponents of every shape
    task automatic random_words(int n);
        logic [W-1:0] m;
        logic [W-1:0] k;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) != 0)
                m = W'($urandom_range(0, 32'(cfg_p) - 1));
            else
                m = W'($urandom);
            case ($urandom_range(0, 9))
                7:       k = W'($urandom_range(0, 15));
                8:       k = W'($urandom_range(0, 1));
                9:       k = ALL_ONES ^ W'($urandom_range(0, 255));
                default: k = W'($urandom);
            endcase
            push_plain(m, k);
        end
    endtask

    // ------------------------------------------------------------------
    // clock, reset, time limit
    // ------------------------------------------------------------------

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #80_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // input driver: offers queued words, predicts on every accepted one
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_idle = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                cipher_q.push_back(elgamal_cipher(tx_word));
                tx_idle = tx_quiet ? 0 : pick_gap();
            end
            // a word still waiting for ready is held as it is
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_idle > 0) begin
                    tx_idle--;
                    s_axis_tvalid <= 1'b0;
                end else if (msg_q.size() != 0) begin
                    tx_word = msg_q.pop_front();
                    s_axis_tdata  <= TD_W'({tx_word.k, tx_word.msg});
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output monitor: checks every accepted word, throttles ready
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_cipher want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_idle = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (cipher_q.size() == 0) begin
                    report_mismatch("unexpected word", m_axis_tdata[W-1:0], '0);
                end else begin
                    want = cipher_q.pop_front();
                    if (m_axis_tdata[W-1:0] !== want.c1)
                        report_mismatch("cipher_first", m_axis_tdata[W-1:0], want.c1);
                    if (m_axis_tdata[2*W-1:W] !== want.c2)
                        report_mismatch("cipher_second", m_axis_tdata[2*W-1:W], want.c2);
                end
                words_out++;
            end
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
            end else if (rx_idle > 0) begin
                rx_idle--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!rx_quiet && $urandom_range(0, 7) == 0)
                    rx_idle = pick_gap();
            end
        end
    end

    // long receiver hold-off mid run: result register fills, then the input stalls
    initial begin
        wait (words_out >= 280);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (30000) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // stimulus: directed special cases, then random key settings
    // ------------------------------------------------------------------

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset keys p=3 g=2 y=1: smallest word, message above p, zero exponent
        push_plain('0, W'(1));
        push_plain(ALL_ONES, ALL_ONES);
        push_plain(W'(2), '0);
        wait_drained();

        // largest modulus, generator equal to p after masking bit 31
        write_reg(REG_MODULUS, APB_DW'(ALL_ONES));
        write_reg(REG_GENERATOR, '1);
        write_reg(REG_PUBLIC_KEY, APB_DW'(ALL_ONES - 1));
        push_plain(W'(ALL_ONES - 1), W'(ALL_ONES - 1));
        push_plain(W'(32'h2aaa_aaaa), W'(32'h5555_5555));
        push_plain(W'(32'h5555_5555), W'(32'h2aaa_aaaa));
        push_plain(ALL_ONES, W'(1));                  // message equal to p
        push_plain(W'(1), '0);
        wait_drained();

        write_reg(REG_GENERATOR, APB_DW'(3));
        write_reg(REG_PUBLIC_KEY, APB_DW'(32'h1234_5678));
        push_plain(W'(ALL_ONES - 1), ALL_ONES);
        push_plain(W'(12345), W'(32'h4000_0000));
        wait_drained();

        // zero modulus: both halves must be zero
        write_reg(REG_MODULUS, '0);
        push_plain(W'(5), W'(7));
        push_plain(ALL_ONES, ALL_ONES);
        wait_drained();

        // modulus of one: zero even for a zero exponent
        write_reg(REG_MODULUS, APB_DW'(1));
        push_plain(ALL_ONES, '0);
        push_plain(W'(3), W'(5));
        wait_drained();

        // composite modulus, generator above p, write to an unused index
        write_reg(REG_MODULUS, APB_DW'(1_000_000));
        write_reg(REG_GENERATOR, APB_DW'(ALL_ONES));
        write_reg(REG_PUBLIC_KEY, APB_DW'(999_999));
        write_reg(REG_NONE, APB_DW'(32'hdead_beef));
        push_plain(W'(999_999), ALL_ONES);
        push_plain(W'(1_000_001), W'(2));
        push_plain('0, W'(3));
        wait_drained();

        // random phases; every third one runs without idling on either side
        for (int ph = 0; ph < 8; ph++) begin
            tx_quiet = (ph % 3 == 1);
            rx_quiet = (ph % 3 == 1);
            random_setting(ph);
            random_words(110);
            wait_drained();
        end

        // catch any stray word after the last one
        repeat (200) @(posedge i_clk);
        if (cipher_q.size() != 0)
            report_mismatch("missing word", '0, cipher_q[0].c1);

        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
